// ===== rtl/leib_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the line editing input buffer.
// No dependencies; used by leib_cell, leib_ring, line_editing_input_buffer, line_buffer_checker and testbench.
package leib_pkg;

   // key codes
   localparam logic [7:0] KEY_NUL    = 8'h00;
   localparam logic [7:0] KEY_CTRL_C = 8'h03;
   localparam logic [7:0] KEY_CTRL_D = 8'h04;
   localparam logic [7:0] KEY_BS     = 8'h08;
   localparam logic [7:0] KEY_NL     = 8'h0A;
   localparam logic [7:0] KEY_CR     = 8'h0D;
   localparam logic [7:0] KEY_CTRL_P = 8'h10;
   localparam logic [7:0] KEY_CTRL_U = 8'h15;
   localparam logic [7:0] KEY_HOME   = 8'h7B;
   localparam logic [7:0] KEY_END    = 8'h7D;
   localparam logic [7:0] KEY_DEL    = 8'h7F;

   // request kinds carried in tuser
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // rotation control for the ring of cells
   typedef struct packed {
      logic fwd;   // cell i takes cell i+1
      logic bwd;   // cell i takes cell i-1
   } shift_type;

   // one result item, line_committed in bit 0
   typedef struct packed {
      logic       end_of_line;
      logic       end_of_file;
      logic       read_empty;
      logic [7:0] read_char;
      logic       read_valid;
      logic       dump_request;
      logic       line_committed;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEEK,
      S_KILL,
      S_INSERT,
      S_DELETE,
      S_COMMIT,
      S_READ,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/leib_cell.sv =====
`timescale 1ns / 1ps
// One byte cell of the circulating line store.
// Depends on leib_pkg for the shift control type.
module leib_cell (
   input  logic               clock,
   input  leib_pkg::shift_type ctrl,
   input  logic [7:0]         next_data,
   input  logic [7:0]         prev_data,
   input  logic               load_en,
   input  logic [7:0]         load_data,
   output logic [7:0]         data
);
   import leib_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // load overrides the neighbor transfer
   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_data;
      end else if (ctrl.fwd) begin
         data_in = next_data;
      end else if (ctrl.bwd) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== rtl/leib_ring.sv =====
`timescale 1ns / 1ps
// Ring of DEPTH byte cells that rotates one place a cycle in either direction.
// Depends on leib_pkg and leib_cell; access is through the first and last cells.
module leib_ring #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  leib_pkg::shift_type ctrl,
   input  logic               load_first_en,
   input  logic [7:0]         load_first_data,
   input  logic               load_last_en,
   input  logic [7:0]         load_last_data,
   output logic [7:0]         first_data,
   output logic [7:0]         last_data
);
   import leib_pkg::*;

   logic [7:0] cell_data [DEPTH];

   // each cell talks only to its two neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic       ld_en;
      logic [7:0] ld_data;
      if (i == 0) begin : g_first
         assign ld_en   = load_first_en;
         assign ld_data = load_first_data;
      end else if (i == DEPTH - 1) begin : g_last
         assign ld_en   = load_last_en;
         assign ld_data = load_last_data;
      end else begin : g_mid
         assign ld_en   = 1'b0;
         assign ld_data = 8'h00;
      end
      leib_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .next_data (cell_data[(i + 1) % DEPTH]),
         .prev_data (cell_data[(i + DEPTH - 1) % DEPTH]),
         .load_en   (ld_en),
         .load_data (ld_data),
         .data      (cell_data[i])
      );
   end

   assign first_data = cell_data[0];
   assign last_data  = cell_data[DEPTH - 1];

endmodule

// ===== rtl/line_editing_input_buffer.sv =====
`timescale 1ns / 1ps
// Keyboard line buffer with an edit cursor: control sequencer over a ring of cells.
// Depends on leib_pkg and leib_ring.
//
// Usage:
//   Requests arrive on req_*: tuser selects a key event or a one-character
//   read, tdata carries the key byte and the read-started flag. Every
//   request gives exactly one result transfer on rsp_*.
//   The line store is a ring of BUFFER_DEPTH byte cells that rotates one
//   place per cycle; only the first and last cells are accessed. A request
//   that needs the store first rotates the ring to the slot it needs the
//   shorter way round, r rotations (r at most BUFFER_DEPTH/2). A read then
//   takes one byte and a commit writes one; an insert or backspace then
//   moves every byte between the cursor and the line end, and a kill steps
//   back over each killed byte. Cursor moves, dump requests, ignored keys
//   and empty reads need no rotation. A new request is accepted only in
//   idle; the output register is loaded as the sequencer returns to idle.
//   A finished result sits in an output register; while the receiver
//   stalls, the next request is still accepted and worked on, and only its
//   result waits for the register to drain.
//   Reset (synchronous) clears all indices and the ring position; the store
//   contents are undefined until written.
module line_editing_input_buffer #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] key_code, [8] read_started, rest zero
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] line_committed, [1] dump_request,
                                    // [2] read_valid, [10:3] read_char,
                                    // [11] read_empty, [12] end_of_file,
                                    // [13] end_of_line, rest zero
);
   import leib_pkg::*;

   localparam int IDX_MOD = 2 * BUFFER_DEPTH;
   localparam int IW      = $clog2(IDX_MOD);
   localparam int SW      = $clog2(BUFFER_DEPTH);

   // index arithmetic modulo 2*depth, slots modulo depth
   function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
      return (a == IW'(IDX_MOD - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
      return (a == '0) ? IW'(IDX_MOD - 1) : a - 1'b1;
   endfunction

   function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a,
                                              input logic [IW-1:0] b);
      return (a >= b) ? a - b : a - b + IW'(IDX_MOD);
   endfunction

   function automatic logic [SW-1:0] idx_slot(input logic [IW-1:0] a);
      return (a >= IW'(BUFFER_DEPTH)) ? SW'(a - IW'(BUFFER_DEPTH)) : SW'(a);
   endfunction

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] a);
      return (a == SW'(BUFFER_DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] a);
      return (a == '0) ? SW'(BUFFER_DEPTH - 1) : a - 1'b1;
   endfunction

   // control and index registers
   state_type     state_ff, state_in;
   state_type     act_ff, act_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] target_ff, target_in;
   logic [IW-1:0] rd_ff, rd_in;
   logic [IW-1:0] cm_ff, cm_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] end_ff, end_in;
   logic [IW-1:0] count_ff, count_in;
   logic          first_ff, first_in;
   logic          started_ff, started_in;
   logic [7:0]    carry_ff, carry_in;
   result_type    res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_data_ff, rsp_data_in;

   // ring interface
   shift_type     ring_ctrl;
   logic          load_first_en, load_last_en;
   logic [7:0]    load_first_data, load_last_data;
   logic [7:0]    cell_first, cell_last;

   // request fields
   logic          req_op;
   logic [7:0]    req_key;
   logic          req_started;
   logic [7:0]    key_ch;
   logic [SW-1:0] seek_diff;
   logic          rsp_free;

   assign req_op      = req_tuser[0];
   assign req_key     = req_tdata[7:0];
   assign req_started = req_tdata[8];
   assign key_ch      = (req_key == KEY_CR) ? KEY_NL : req_key;

   assign seek_diff = (target_ff >= head_ff) ? target_ff - head_ff
                                             : target_ff - head_ff + SW'(BUFFER_DEPTH);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);

   leib_ring #(.DEPTH(BUFFER_DEPTH)) u_ring (
      .clock           (clock),
      .ctrl            (ring_ctrl),
      .load_first_en   (load_first_en),
      .load_first_data (load_first_data),
      .load_last_en    (load_last_en),
      .load_last_data  (load_last_data),
      .first_data      (cell_first),
      .last_data       (cell_last)
   );

   // sequencer: next state, indices and ring control
   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      target_in       = target_ff;
      rd_in           = rd_ff;
      cm_in           = cm_ff;
      cur_in          = cur_ff;
      end_in          = end_ff;
      count_in        = count_ff;
      first_in        = first_ff;
      started_in      = started_ff;
      carry_in        = carry_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      ring_ctrl       = '0;
      load_first_en   = 1'b0;
      load_first_data = carry_ff;
      load_last_en    = 1'b0;
      load_last_data  = carry_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               res_in     = '0;
               state_in   = S_FINISH;
               started_in = req_started;
               first_in   = 1'b1;
               if (req_op == OP_READ) begin
                  if (rd_ff == cm_ff) begin
                     res_in.read_empty = 1'b1;
                  end else begin
                     target_in = idx_slot(rd_ff);
                     act_in    = S_READ;
                     state_in  = S_SEEK;
                  end
               end else begin
                  case (req_key)
                     KEY_HOME: cur_in = cm_ff;
                     KEY_END:  cur_in = end_ff;
                     KEY_CTRL_P: res_in.dump_request = 1'b1;
                     KEY_CTRL_C, KEY_CTRL_U: begin
                        target_in = idx_slot(end_ff);
                        act_in    = S_KILL;
                        state_in  = S_SEEK;
                     end
                     KEY_BS, KEY_DEL: begin
                        if (cur_ff != cm_ff) begin
                           target_in = idx_slot(end_ff);
                           count_in  = idx_dist(end_ff, cur_ff) + 1'b1;
                           act_in    = S_DELETE;
                           state_in  = S_SEEK;
                        end
                     end
                     KEY_NUL: ;
                     default: begin
                        if (idx_dist(end_ff, rd_ff) < IW'(BUFFER_DEPTH)) begin
                           carry_in = key_ch;
                           state_in = S_SEEK;
                           if (key_ch == KEY_NL || key_ch == KEY_CTRL_D ||
                               idx_dist(end_ff, rd_ff) == IW'(BUFFER_DEPTH - 1)) begin
                              target_in = idx_slot(end_ff);
                              act_in    = S_COMMIT;
                           end else begin
                              target_in = idx_slot(cur_ff);
                              count_in  = idx_dist(end_ff, cur_ff) + 1'b1;
                              act_in    = S_INSERT;
                           end
                        end
                     end
                  endcase
               end
            end
         end

         // rotate the shorter way until the target slot sits in the first cell
         S_SEEK: begin
            if (head_ff == target_ff) begin
               state_in = act_ff;
            end else if (seek_diff <= SW'(BUFFER_DEPTH / 2)) begin
               ring_ctrl.fwd = 1'b1;
            end else begin
               ring_ctrl.bwd = 1'b1;
            end
         end

         // last cell holds the byte before end
         S_KILL: begin
            if (end_ff != cm_ff && cell_last != KEY_NL) begin
               ring_ctrl.bwd = 1'b1;
               end_in        = idx_dec(end_ff);
               if (cur_ff != cm_ff) begin
                  cur_in = idx_dec(cur_ff);
               end
            end else begin
               state_in = S_FINISH;
            end
         end

         // walk up from the cursor, each slot takes the byte below it
         S_INSERT: begin
            ring_ctrl.fwd = 1'b1;
            load_last_en  = 1'b1;
            carry_in      = cell_first;
            count_in      = count_ff - 1'b1;
            if (count_ff == IW'(1)) begin
               cur_in   = idx_inc(cur_ff);
               end_in   = idx_inc(end_ff);
               state_in = S_FINISH;
            end
         end

         // walk down from end-1, each slot takes the byte above it
         S_DELETE: begin
            ring_ctrl.bwd = 1'b1;
            load_first_en = !first_ff;
            carry_in      = cell_last;
            first_in      = 1'b0;
            count_in      = count_ff - 1'b1;
            if (count_ff == IW'(1)) begin
               cur_in   = idx_dec(cur_ff);
               end_in   = idx_dec(end_ff);
               state_in = S_FINISH;
            end
         end

         S_COMMIT: begin
            load_first_en         = 1'b1;
            end_in                = idx_inc(end_ff);
            cur_in                = idx_inc(end_ff);
            cm_in                 = idx_inc(end_ff);
            res_in.line_committed = 1'b1;
            state_in              = S_FINISH;
         end

         S_READ: begin
            state_in = S_FINISH;
            if (cell_first == KEY_CTRL_D) begin
               res_in.end_of_file = 1'b1;
               if (!started_ff) begin
                  rd_in = idx_inc(rd_ff);
               end
            end else begin
               rd_in              = idx_inc(rd_ff);
               res_in.read_valid  = 1'b1;
               res_in.read_char   = cell_first;
               res_in.end_of_line = (cell_first == KEY_NL);
            end
         end

         // hand the result to the output register once it has room
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // ring position follows the rotation
      if (ring_ctrl.fwd) begin
         head_in = slot_inc(head_ff);
      end else if (ring_ctrl.bwd) begin
         head_in = slot_dec(head_ff);
      end else begin
         head_in = head_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= S_IDLE;
         head_ff      <= '0;
         rd_ff        <= '0;
         cm_ff        <= '0;
         cur_ff       <= '0;
         end_ff       <= '0;
         count_ff     <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         head_ff      <= head_in;
         rd_ff        <= rd_in;
         cm_ff        <= cm_in;
         cur_ff       <= cur_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      started_ff  <= started_in;
      carry_ff    <= carry_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // kill loop keeps the ring aligned with the line end
   a_kill_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_KILL |-> head_ff == idx_slot(end_ff))
      else $error("ring position lost track of line end during kill");

   // buffered data never exceeds the store
   a_room: assert property (@(posedge clock) disable iff (reset)
      idx_dist(end_ff, rd_ff) <= IW'(BUFFER_DEPTH))
      else $error("line store overfilled");

   // cursor stays inside the open line
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      idx_dist(cur_ff, cm_ff) <= idx_dist(end_ff, cm_ff))
      else $error("cursor outside the open line");

   // a pending result waits while the output register is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && rsp_valid_ff && !rsp_tready |=> state_ff == S_FINISH)
      else $error("result dropped while output stalled");

endmodule

// ===== verif/line_buffer_checker.sv =====
`timescale 1ns / 1ps
// Watches both streams of the line editing input buffer, tracks the line store and
// indices on its own, and scores every result transfer. Depends on leib_pkg.
module line_buffer_checker #(
   parameter int BUFFER_DEPTH = 128   // indices are 8 bits, i.e. modulo 2*128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] key_code, [8] read_started
   input  logic [0:0]  req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // result_type in [13:0]
   output int          fail_count,
   output int          results_owed
);
   import leib_pkg::*;

   // shadow of the line store and its four ring indices
   logic [7:0] line_mem [0:BUFFER_DEPTH-1];
   logic [7:0] rd_at, commit_at, cursor_at, end_at;

   result_type buffer_results [$];
   int         failures;

   function automatic int slot_of(input logic [7:0] idx);
      return idx % BUFFER_DEPTH;
   endfunction

   // apply one request to the shadow state and return the result it gives
   function automatic result_type edit_line_buffer(input logic op, input logic [7:0] key,
                                                   input logic started);
      result_type r;
      logic [7:0] c, i, nxt, last, fill;
      r = '0;
      if (op == OP_READ) begin
         if (rd_at == commit_at) begin
            r.read_empty = 1'b1;
         end else begin
            c = line_mem[slot_of(rd_at)];
            if (c == KEY_CTRL_D) begin
               // end of file; stays in place if this read already returned data
               r.end_of_file = 1'b1;
               if (!started)
                  rd_at = rd_at + 8'd1;
            end else begin
               rd_at = rd_at + 8'd1;
               r.read_valid  = 1'b1;
               r.read_char   = c;
               r.end_of_line = (c == KEY_NL);
            end
         end
      end else if (key == KEY_HOME) begin
         cursor_at = commit_at;
      end else if (key == KEY_END) begin
         cursor_at = end_at;
      end else if (key == KEY_CTRL_P) begin
         r.dump_request = 1'b1;
      end else if (key == KEY_CTRL_C || key == KEY_CTRL_U) begin
         // kill back to the last newline or the commit point
         while (end_at != commit_at && line_mem[slot_of(end_at - 8'd1)] != KEY_NL) begin
            if (cursor_at != commit_at)
               cursor_at = cursor_at - 8'd1;
            end_at = end_at - 8'd1;
         end
      end else if (key == KEY_BS || key == KEY_DEL) begin
         if (cursor_at != commit_at) begin
            i    = cursor_at - 8'd1;
            last = end_at - 8'd1;
            while (i != last) begin
               nxt = i + 8'd1;
               line_mem[slot_of(i)] = line_mem[slot_of(nxt)];
               i = nxt;
            end
            cursor_at = cursor_at - 8'd1;
            end_at    = end_at - 8'd1;
         end
      end else begin
         fill = end_at - rd_at;
         if (key != KEY_NUL && fill < BUFFER_DEPTH) begin
            c = (key == KEY_CR) ? KEY_NL : key;
            if (c == KEY_NL || c == KEY_CTRL_D || fill == BUFFER_DEPTH - 1) begin
               // append at line end and commit
               line_mem[slot_of(end_at)] = c;
               end_at    = end_at + 8'd1;
               cursor_at = end_at;
               commit_at = end_at;
               r.line_committed = 1'b1;
            end else begin
               // open a hole at the cursor
               i = end_at;
               while (i != cursor_at) begin
                  nxt = i - 8'd1;
                  line_mem[slot_of(i)] = line_mem[slot_of(nxt)];
                  i = nxt;
               end
               line_mem[slot_of(cursor_at)] = c;
               cursor_at = cursor_at + 8'd1;
               end_at    = end_at + 8'd1;
            end
         end
      end
      return r;
   endfunction

   // score result transfers first, then predict for the request transfer
   always @(posedge clock) begin : track
      result_type got, want;
      int k;
      if (reset) begin
         for (k = 0; k < BUFFER_DEPTH; k++)
            line_mem[k] = 8'd0;
         rd_at = 8'd0;
         commit_at = 8'd0;
         cursor_at = 8'd0;
         end_at = 8'd0;
         buffer_results.delete();
         failures = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[13:0];
            if (buffer_results.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result transfer %h with no request pending", $time,
                           rsp_tdata);
               failures++;
            end else begin
               want = buffer_results.pop_front();
               if (got.line_committed !== want.line_committed ||
                   got.dump_request !== want.dump_request ||
                   got.read_valid !== want.read_valid ||
                   got.read_char !== want.read_char ||
                   got.read_empty !== want.read_empty ||
                   got.end_of_file !== want.end_of_file ||
                   got.end_of_line !== want.end_of_line) begin
                  if (failures < 10) begin
                     $display("%0t: mismatch commit/dump/valid/char/empty/eof/eol", $time);
                     $display("   expected %b %b %b %h %b %b %b", want.line_committed,
                              want.dump_request, want.read_valid, want.read_char,
                              want.read_empty, want.end_of_file, want.end_of_line);
                     $display("   actual   %b %b %b %h %b %b %b", got.line_committed,
                              got.dump_request, got.read_valid, got.read_char,
                              got.read_empty, got.end_of_file, got.end_of_line);
                  end
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready)
            buffer_results.push_back(edit_line_buffer(req_tuser[0], req_tdata[7:0],
                                                      req_tdata[8]));
      end
      fail_count   <= failures;
      results_owed <= buffer_results.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the line editing input buffer test: clock, reset, key and read traffic,
// receiver stalls and verdict. Depends on leib_pkg, line_buffer_checker and the RTL.
module testbench;
   import leib_pkg::*;

   localparam int ITEM_COUNT   = 1350;
   localparam int LONG_HOLD    = 400;    // receiver hold-off, cycles
   localparam int QUIET_LIMIT  = 3000;   // cycles without any transfer
   localparam int DRAIN_CYCLES = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [15:0] rsp_tdata;

   int fail_total;
   int results_owed;
   int items_sent = 0;
   int burst_left = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int quiet_cycles = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   line_editing_input_buffer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   line_buffer_checker CHECK (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_total),
      .results_owed (results_owed)
   );

   // one request transfer; bursts of random length with random gaps between
   task automatic send_item(input logic op, input logic [7:0] key, input logic started);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0)
            gap = 0;
         else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(8, 30);
         else
            gap = $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, started, key};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic press(input logic [7:0] key);
      send_item(OP_KEY, key, 1'($urandom_range(0, 1)));
   endtask

   task automatic fetch(input logic started);
      send_item(OP_READ, 8'($urandom_range(0, 255)), started);
   endtask

   // printable byte that is not a cursor move
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(8'h20, 8'h7E));
      while (c == KEY_HOME || c == KEY_END);
      return c;
   endfunction

   // type past full without reading, then read it all back
   task automatic flood();
      repeat ($urandom_range(128, 136)) press(plain_char());
      repeat ($urandom_range(130, 140)) fetch(1'b0);
   endtask

   // key and read traffic
   initial begin : stimulus
      int len, k, pick;
      logic paused_once;
      paused_once = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty read, edits at both ends, no-op delete, ignored byte
      fetch(1'b0);
      press(8'h61);
      press(8'hFF);
      press(KEY_HOME);
      press(8'h62);
      press(KEY_DEL);
      press(KEY_HOME);
      press(KEY_BS);
      press(KEY_END);
      press(KEY_NUL);
      press(KEY_CTRL_P);
      press(KEY_CR);
      fetch(1'b0);
      fetch(1'b1);
      fetch(1'b1);
      // kills, newline commit, end of file kept then consumed
      press(8'h78);
      press(8'h79);
      press(KEY_CTRL_U);
      press(8'h7A);
      press(KEY_CTRL_C);
      press(8'h71);
      press(KEY_NL);
      press(KEY_CTRL_D);
      fetch(1'b0);
      fetch(1'b1);
      fetch(1'b1);
      fetch(1'b0);
      fetch(1'b0);

      // full buffer commit at least once
      flood();

      while (items_sent < ITEM_COUNT) begin
         if (holds_asked == 0 && items_sent > 400)
            holds_asked = 1;
         if (!paused_once && items_sent > 800) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait (results_owed == 0);
            paused_once = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            // edit a line, mostly end it, read some of it back
            len = $urandom_range(1, 14);
            for (k = 0; k < len; k++) begin
               pick = $urandom_range(0, 19);
               if (pick < 13)
                  press(plain_char());
               else
                  case ($urandom_range(0, 7))
                     0: press(KEY_HOME);
                     1: press(KEY_END);
                     2: press(KEY_BS);
                     3: press(KEY_DEL);
                     4: press(KEY_CTRL_P);
                     5: press(KEY_NUL);
                     6: press(KEY_CTRL_C);
                     default: press(KEY_CTRL_U);
                  endcase
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3: press(KEY_NL);
               4, 5, 6:    press(KEY_CR);
               7, 8:       press(KEY_CTRL_D);
               default:    ;
            endcase
            repeat ($urandom_range(0, len + 3)) fetch($urandom_range(0, 3) == 0);
         end else if (pick < 15) begin
            repeat ($urandom_range(1, 20)) fetch($urandom_range(0, 3) == 0);
         end else if (pick < 19) begin
            // noise
            repeat (10) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
         end else begin
            flood();
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (results_owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_total == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // receiver: stall pattern changes per segment; one long hold-off on request
   initial begin : receiver
      int mode, seg, n;
      forever begin
         mode = $urandom_range(0, 3);
         seg  = $urandom_range(20, 200);
         for (n = 0; n < seg; n++) begin
            @(negedge clock);
            if (holds_done != holds_asked) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD - 1) @(negedge clock);
               holds_done++;
            end else begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= 1'($urandom_range(0, 1));
                  2:       rsp_tready <= (n % 4 == 0);
                  default: rsp_tready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule
